>>> rtl/core/sbcc_pkg.sv
// Shared types, widths and codes for the segment versus box collision check.
package sbcc_pkg;

    localparam int COORD_BITS = 16;
    localparam int REG_BITS   = 15;
    localparam int DIFF_BITS  = COORD_BITS + 2;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int AREA_BITS  = PROD_BITS + 1;
    localparam int WIDE_BITS  = COORD_BITS + 1;

    // Five planes, two 2D tests each, four orientation areas per test.
    localparam int PLANE_COUNT = 5;
    localparam int TEST_COUNT  = 2 * PLANE_COUNT;
    localparam int AREA_COUNT  = 4 * TEST_COUNT;

    typedef enum logic [1:0] {
        REG_DEPTH      = 2'd0,
        REG_HALF_WIDTH = 2'd1,
        REG_HEIGHT     = 2'd2
    } reg_index_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [WIDE_BITS-1:0]  wcoord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;

    typedef struct packed {
        wcoord_t ax;
        wcoord_t ay;
        wcoord_t bx;
        wcoord_t by;
    } seg2_t;

    // One 2D test: segment p against segment v.
    typedef struct packed {
        seg2_t p;
        seg2_t v;
    } test_t;

    // Operands of one orientation area: (dx1*dy2) - (dy1*dx2).
    typedef struct packed {
        diff_t m1a;
        diff_t m1b;
        diff_t m2a;
        diff_t m2b;
    } area_ops_t;

    // Sign code of one area: neg, nonzero.
    typedef struct packed {
        logic neg;
        logic nz;
    } sgn_t;

    function automatic area_ops_t orient_ops(wcoord_t px, wcoord_t py, wcoord_t qx,
                                             wcoord_t qy, wcoord_t rx, wcoord_t ry);
        area_ops_t o;
        o.m1a = DIFF_BITS'(qx) - DIFF_BITS'(px);
        o.m1b = DIFF_BITS'(ry) - DIFF_BITS'(py);
        o.m2a = DIFF_BITS'(qy) - DIFF_BITS'(py);
        o.m2b = DIFF_BITS'(rx) - DIFF_BITS'(px);
        return o;
    endfunction

    function automatic logic same_strict(sgn_t a, sgn_t b);
        return a.nz && b.nz && (a.neg == b.neg);
    endfunction

endpackage

>>> rtl/core/sbcc_setup.sv
// Stage one: inside test and operand differences for all orientation areas.
module sbcc_setup
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    advance,
    input  logic                                    in_valid,
    input  sbcc_pkg::coord_t                        sx,
    input  sbcc_pkg::coord_t                        sy,
    input  sbcc_pkg::coord_t                        sz,
    input  sbcc_pkg::coord_t                        ex,
    input  sbcc_pkg::coord_t                        ey,
    input  sbcc_pkg::coord_t                        ez,
    input  logic [sbcc_pkg::REG_BITS-1:0]           depth,
    input  logic [sbcc_pkg::REG_BITS-1:0]           half_width,
    input  logic [sbcc_pkg::REG_BITS-1:0]           height,
    output logic                                    valid_reg,
    output logic                                    inside_reg,
    output sbcc_pkg::area_ops_t [sbcc_pkg::AREA_COUNT-1:0] ops_reg
);
    import sbcc_pkg::*;

    wcoord_t d, w, nw, h, z0;
    wcoord_t s [3];
    wcoord_t e [3];
    test_t   tests [TEST_COUNT];
    area_ops_t [AREA_COUNT-1:0] ops_next;
    logic inside_next;

    function automatic logic in_box(wcoord_t x, wcoord_t y, wcoord_t z,
                                    wcoord_t dd, wcoord_t ww, wcoord_t nn, wcoord_t hh);
        return (x > 0) && (x < dd) && (y > nn) && (y < ww) && (z > 0) && (z < hh);
    endfunction

    function automatic seg2_t mk(wcoord_t ax, wcoord_t ay, wcoord_t bx, wcoord_t by);
        seg2_t r;
        r.ax = ax; r.ay = ay; r.bx = bx; r.by = by;
        return r;
    endfunction

    always_comb
    begin
        d  = WIDE_BITS'($signed({1'b0, depth}));
        w  = WIDE_BITS'($signed({1'b0, half_width}));
        h  = WIDE_BITS'($signed({1'b0, height}));
        nw = -w;
        z0 = '0;
        s[0] = WIDE_BITS'(sx); s[1] = WIDE_BITS'(sy); s[2] = WIDE_BITS'(sz);
        e[0] = WIDE_BITS'(ex); e[1] = WIDE_BITS'(ey); e[2] = WIDE_BITS'(ez);
        inside_next = in_box(s[0], s[1], s[2], d, w, nw, h)
                   && in_box(e[0], e[1], e[2], d, w, nw, h);
        // front, top, rear, +y side, -y side; (first test, second test)
        tests[0] = '{p: mk(s[0], s[2], e[0], e[2]), v: mk(z0, z0, z0, h)};
        tests[1] = '{p: mk(s[0], s[1], e[0], e[1]), v: mk(z0, w, z0, nw)};
        tests[2] = '{p: mk(s[0], s[2], e[0], e[2]), v: mk(z0, h, d, h)};
        tests[3] = '{p: mk(s[0], s[1], e[0], e[1]), v: mk(z0, w, z0, nw)};
        tests[4] = '{p: mk(s[0], s[2], e[0], e[2]), v: mk(d, h, d, z0)};
        tests[5] = '{p: mk(s[0], s[1], e[0], e[1]), v: mk(d, w, d, nw)};
        tests[6] = '{p: mk(s[1], s[2], e[1], e[2]), v: mk(w, z0, w, h)};
        tests[7] = '{p: mk(s[0], s[1], e[0], e[1]), v: mk(z0, w, d, w)};
        tests[8] = '{p: mk(s[1], s[2], e[1], e[2]), v: mk(nw, z0, nw, h)};
        tests[9] = '{p: mk(s[0], s[1], e[0], e[1]), v: mk(z0, nw, d, nw)};
        for (int t = 0; t < TEST_COUNT; t++)
        begin
            ops_next[4*t+0] = orient_ops(tests[t].p.ax, tests[t].p.ay, tests[t].p.bx,
                                         tests[t].p.by, tests[t].v.ax, tests[t].v.ay);
            ops_next[4*t+1] = orient_ops(tests[t].p.ax, tests[t].p.ay, tests[t].p.bx,
                                         tests[t].p.by, tests[t].v.bx, tests[t].v.by);
            ops_next[4*t+2] = orient_ops(tests[t].v.ax, tests[t].v.ay, tests[t].v.bx,
                                         tests[t].v.by, tests[t].p.ax, tests[t].p.ay);
            ops_next[4*t+3] = orient_ops(tests[t].v.ax, tests[t].v.ay, tests[t].v.bx,
                                         tests[t].v.by, tests[t].p.bx, tests[t].p.by);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            inside_reg <= inside_next;
            ops_reg    <= ops_next;
        end
    end

endmodule

>>> rtl/core/sbcc_mult.sv
// Stage two: the two products of every orientation area.
module sbcc_mult
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          advance,
    input  logic                                          in_valid,
    input  logic                                          in_inside,
    input  sbcc_pkg::area_ops_t [sbcc_pkg::AREA_COUNT-1:0] ops,
    output logic                                          valid_reg,
    output logic                                          inside_reg,
    output sbcc_pkg::prod_t [sbcc_pkg::AREA_COUNT-1:0]    p1_reg,
    output sbcc_pkg::prod_t [sbcc_pkg::AREA_COUNT-1:0]    p2_reg
);
    import sbcc_pkg::*;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            inside_reg <= in_inside;
            for (int i = 0; i < AREA_COUNT; i++)
            begin
                p1_reg[i] <= PROD_BITS'(ops[i].m1a * ops[i].m1b);
                p2_reg[i] <= PROD_BITS'(ops[i].m2a * ops[i].m2b);
            end
        end
    end

endmodule

>>> rtl/core/sbcc_sign.sv
// Stage three: area signs; stage four: per-test and per-plane decision.
module sbcc_sign
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       advance,
    input  logic                                       in_valid,
    input  logic                                       in_inside,
    input  sbcc_pkg::prod_t [sbcc_pkg::AREA_COUNT-1:0] p1,
    input  sbcc_pkg::prod_t [sbcc_pkg::AREA_COUNT-1:0] p2,
    output logic                                       valid_reg,
    output logic                                       hit_reg
);
    import sbcc_pkg::*;

    logic signed [AREA_BITS-1:0] area [AREA_COUNT];
    sgn_t [AREA_COUNT-1:0] sgn_next, sgn_reg;
    logic [TEST_COUNT-1:0] test_hit;
    logic [PLANE_COUNT-1:0] plane_hit;
    logic v3_reg, inside3_reg, hit_next;

    always_comb
    begin
        for (int i = 0; i < AREA_COUNT; i++)
        begin
            area[i] = AREA_BITS'(p1[i]) - AREA_BITS'(p2[i]);
            sgn_next[i].neg = area[i][AREA_BITS-1];
            sgn_next[i].nz  = |area[i];
        end
    end

    always_comb
    begin
        for (int t = 0; t < TEST_COUNT; t++)
        begin
            test_hit[t] = !(same_strict(sgn_reg[4*t], sgn_reg[4*t+1])
                         || same_strict(sgn_reg[4*t+2], sgn_reg[4*t+3]));
        end
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            plane_hit[p] = test_hit[2*p] && test_hit[2*p+1];
        end
        hit_next = inside3_reg || (|plane_hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v3_reg    <= in_valid;
            valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sgn_reg     <= sgn_next;
            inside3_reg <= in_inside;
            hit_reg     <= hit_next;
        end
    end

endmodule

>>> rtl/core/segment_box_collision_check.sv
// Top level of the segment versus box collision check.
// Takes one 3D segment per transfer (signed Q3.12 endpoints in the box frame) and
// returns one hit bit per segment, in order. The box spans 0..box_depth in x,
// -box_half_width..box_half_width in y and 0..box_height in z. A segment whose
// endpoints both lie strictly inside hits; otherwise it hits when any of the
// front, top, rear and two side planes has both of its 2D orientation tests hit
// (touching and collinear count as hits). The pipeline has four register stages:
// setup of differences, one multiplier per product (forty areas, two products
// each), area sign, and plane decision into the output register. One segment is
// accepted every cycle while the output is not stalled; a stall on the output
// freezes the whole pipeline, and an empty output register lets bubbles move
// along under a stall.
// Write box registers only while no segment is in flight.
module segment_box_collision_check
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [sbcc_pkg::REG_BITS-1:0]     cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  sbcc_pkg::coord_t                  start_x,
    input  sbcc_pkg::coord_t                  start_y,
    input  sbcc_pkg::coord_t                  start_z,
    input  sbcc_pkg::coord_t                  end_x,
    input  sbcc_pkg::coord_t                  end_y,
    input  sbcc_pkg::coord_t                  end_z,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              hit
);
    import sbcc_pkg::*;

    logic [REG_BITS-1:0] depth_reg, half_width_reg, height_reg;
    logic advance;
    logic v1, in1, v2, in2;
    area_ops_t [AREA_COUNT-1:0] ops1;
    prod_t [AREA_COUNT-1:0] p1, p2;

    // Advance the whole pipe when the output register is free or being taken.
    assign advance  = !out_stall || !out_valid;
    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg      <= '0;
            half_width_reg <= '0;
            height_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEPTH:      depth_reg      <= cfg_data;
                REG_HALF_WIDTH: half_width_reg <= cfg_data;
                REG_HEIGHT:     height_reg     <= cfg_data;
                default:        ;
            endcase
        end
    end

    sbcc_setup u_setup
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_valid   (in_valid),
        .sx         (start_x),
        .sy         (start_y),
        .sz         (start_z),
        .ex         (end_x),
        .ey         (end_y),
        .ez         (end_z),
        .depth      (depth_reg),
        .half_width (half_width_reg),
        .height     (height_reg),
        .valid_reg  (v1),
        .inside_reg (in1),
        .ops_reg    (ops1)
    );

    sbcc_mult u_mult
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_valid   (v1),
        .in_inside  (in1),
        .ops        (ops1),
        .valid_reg  (v2),
        .inside_reg (in2),
        .p1_reg     (p1),
        .p2_reg     (p2)
    );

    sbcc_sign u_sign
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (v2),
        .in_inside (in2),
        .p1        (p1),
        .p2        (p2),
        .valid_reg (out_valid),
        .hit_reg   (hit)
    );

    // Hold the result while the consumer stalls.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit))
        else $error("result changed under stall");
    a_nostall_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall && !in_valid && !v1 && !v2 |=> !v1)
        else $error("bubble became valid");

endmodule

>>> test/testbench.sv
// Self-checking testbench for the segment versus box collision check.
`timescale 1ns / 100ps

module testbench;
    import sbcc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 12;

    typedef struct {
        coord_t sx, sy, sz, ex, ey, ez;
    } segment_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [REG_BITS-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    coord_t start_x, start_y, start_z, end_x, end_y, end_z;
    logic out_valid;
    logic out_stall;
    logic hit;

    segment_box_collision_check u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .start_x   (start_x),
        .start_y   (start_y),
        .start_z   (start_z),
        .end_x     (end_x),
        .end_y     (end_y),
        .end_z     (end_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hit       (hit)
    );

    // Box dimensions as the testbench believes them to be.
    longint box_d, box_w, box_h;

    segment_t pending_segments[$];
    bit       expected_hits[$];
    int       failures;
    int       send_idle_pct;
    int       recv_idle_pct;
    int       hold_cycles;
    int       quiet_cycles;

    // Sign of the orientation area of r against directed p-q; exact in 64 bits.
    function automatic int area_sign(longint px, longint py, longint qx, longint qy,
                                     longint rx, longint ry);
        longint a;
        a = (qx - px) * (ry - py) - (qy - py) * (rx - px);
        return (a > 0) ? 1 : ((a < 0) ? -1 : 0);
    endfunction

    // Two 2D segments cross unless one lies strictly on one side of the other.
    function automatic bit crosses(longint p1x, longint p1y, longint p2x, longint p2y,
                                   longint v1x, longint v1y, longint v2x, longint v2y);
        int a1, a2, b1, b2;
        a1 = area_sign(p1x, p1y, p2x, p2y, v1x, v1y);
        a2 = area_sign(p1x, p1y, p2x, p2y, v2x, v2y);
        b1 = area_sign(v1x, v1y, v2x, v2y, p1x, p1y);
        b2 = area_sign(v1x, v1y, v2x, v2y, p2x, p2y);
        return !((a1 * a2 > 0) || (b1 * b2 > 0));
    endfunction

    function automatic bit strictly_in(longint x, longint y, longint z);
        return x > 0 && x < box_d && y > -box_w && y < box_w && z > 0 && z < box_h;
    endfunction

    function automatic bit predict_hit(segment_t s);
        longint sx, sy, sz, ex, ey, ez, d, w, h;
        sx = s.sx; sy = s.sy; sz = s.sz; ex = s.ex; ey = s.ey; ez = s.ez;
        d = box_d; w = box_w; h = box_h;
        if (strictly_in(sx, sy, sz) && strictly_in(ex, ey, ez))
            return 1'b1;
        // Front, top (its x-y test uses the line x = 0), rear, +y side, -y side.
        if (crosses(sx, sz, ex, ez, 0, 0, 0, h) && crosses(sx, sy, ex, ey, 0, w, 0, -w))
            return 1'b1;
        if (crosses(sx, sz, ex, ez, 0, h, d, h) && crosses(sx, sy, ex, ey, 0, w, 0, -w))
            return 1'b1;
        if (crosses(sx, sz, ex, ez, d, h, d, 0) && crosses(sx, sy, ex, ey, d, w, d, -w))
            return 1'b1;
        if (crosses(sy, sz, ey, ez, w, 0, w, h) && crosses(sx, sy, ex, ey, 0, w, d, w))
            return 1'b1;
        if (crosses(sy, sz, ey, ez, -w, 0, -w, h) && crosses(sx, sy, ex, ey, 0, -w, d, -w))
            return 1'b1;
        return 1'b0;
    endfunction

    function automatic segment_t make_segment(int sx, int sy, int sz, int ex, int ey, int ez);
        segment_t s;
        s.sx = coord_t'(sx); s.sy = coord_t'(sy); s.sz = coord_t'(sz);
        s.ex = coord_t'(ex); s.ey = coord_t'(ey); s.ez = coord_t'(ez);
        return s;
    endfunction

    // Coordinate near the box most of the time, anywhere otherwise.
    function automatic int pick_coord(longint lo, longint hi);
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return int'($urandom_range(0, 65535)) - 32768;
        if (r < 4)
            return int'(lo + ((r == 2) ? 0 : hi - lo));
        return int'(lo - 200 + longint'($urandom_range(0, 400 + 32'(hi - lo))));
    endfunction

    function automatic segment_t random_segment();
        segment_t s;
        s.sx = coord_t'(pick_coord(0, box_d));
        s.sy = coord_t'(pick_coord(-box_w, box_w));
        s.sz = coord_t'(pick_coord(0, box_h));
        if ($urandom_range(0, 9) == 0)
        begin
            s.ex = s.sx; s.ey = s.sy; s.ez = s.sz;
        end
        else
        begin
            s.ex = coord_t'(pick_coord(0, box_d));
            s.ey = coord_t'(pick_coord(-box_w, box_w));
            s.ez = coord_t'(pick_coord(0, box_h));
        end
        return s;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Write one box register at a clock edge; the block must be idle.
    task automatic write_reg(reg_index_t idx, int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= REG_BITS'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_DEPTH:      box_d = value & 32'h7FFF;
            REG_HALF_WIDTH: box_w = value & 32'h7FFF;
            default:        box_h = value & 32'h7FFF;
        endcase
    endtask

    task automatic set_box(int d, int w, int h);
        write_reg(REG_DEPTH, d);
        write_reg(REG_HALF_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    // Wait until all transfers are done and results are back, then let the pipe settle.
    task automatic wait_drained();
        while (pending_segments.size() != 0 || expected_hits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic queue_random(int count);
        repeat (count) pending_segments.push_back(random_segment());
    endtask

    // Stimulus: directed extremes first, then random phases across box settings.
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        box_d = 0; box_w = 0; box_h = 0;
        failures = 0;
        send_idle_pct = 11;
        recv_idle_pct = 54;
        hold_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Zero-sized box straight out of reset.
        pending_segments.push_back(make_segment(0, 0, 0, 0, 0, 0));
        pending_segments.push_back(make_segment(-32768, -32768, -32768, 32767, 32767, 32767));
        pending_segments.push_back(make_segment(100, 100, 100, 200, 200, 200));
        wait_drained();

        set_box(8192, 4096, 6144);
        // Inside, outside, crossing each plane, touching corner, degenerate, extremes.
        pending_segments.push_back(make_segment(100, 0, 100, 8000, 100, 6000));
        pending_segments.push_back(make_segment(-1000, 0, 3000, 1000, 0, 3000));
        pending_segments.push_back(make_segment(4000, 0, 7000, 4000, 0, 5000));
        pending_segments.push_back(make_segment(9000, 0, 3000, 7000, 0, 3000));
        pending_segments.push_back(make_segment(4000, 5000, 3000, 4000, 3000, 3000));
        pending_segments.push_back(make_segment(4000, -5000, 3000, 4000, -3000, 3000));
        pending_segments.push_back(make_segment(0, 0, 0, 0, 0, 0));
        pending_segments.push_back(make_segment(8192, 4096, 6144, 9000, 5000, 7000));
        pending_segments.push_back(make_segment(-20000, -20000, -20000, -10000, -10000, -10000));
        pending_segments.push_back(make_segment(32767, 32767, 32767, 32767, 32767, 32767));
        pending_segments.push_back(make_segment(-32768, 0, 0, 32767, 0, 0));
        pending_segments.push_back(make_segment(-32768, -32768, 32767, 32767, 32767, -32768));
        pending_segments.push_back(make_segment(0, 0, 6144, 8192, 0, 6144));
        pending_segments.push_back(make_segment(20000, 20000, 20000, 20001, 20001, 20001));
        wait_drained();

        set_box(32767, 32767, 32767);
        pending_segments.push_back(make_segment(1, -32767, 1, 32766, 32766, 32766));
        pending_segments.push_back(make_segment(-32768, -32768, -32768, 32767, 32767, 32767));
        queue_random(300);
        wait_drained();

        // Other way round for idling; register bits above the field are dropped.
        send_idle_pct = 54;
        recv_idle_pct = 11;
        write_reg(REG_DEPTH, 32'h0001_2000);
        write_reg(REG_HALF_WIDTH, 300);
        write_reg(REG_HEIGHT, 0);
        queue_random(300);
        wait_drained();

        // Receiver holds off for a long stretch while the sender keeps offering.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_box(2048, 1024, 3000);
        hold_cycles = 60;
        queue_random(300);
        wait_drained();

        set_box(0, 5000, 16384);
        queue_random(150);
        wait_drained();
        set_box(12000, 8000, 100);
        queue_random(200);
        wait_drained();

        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Driver: present the next segment; advance only on an accepted transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            start_x <= '0; start_y <= '0; start_z <= '0;
            end_x <= '0; end_y <= '0; end_z <= '0;
        end
        else
        begin
            automatic bit taken = in_valid && !in_stall;
            if (taken)
            begin
                expected_hits.push_back(predict_hit(pending_segments.pop_front()));
            end
            if ((!in_valid || taken) && pending_segments.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                start_x <= pending_segments[0].sx;
                start_y <= pending_segments[0].sy;
                start_z <= pending_segments[0].sz;
                end_x   <= pending_segments[0].ex;
                end_y   <= pending_segments[0].ey;
                end_z   <= pending_segments[0].ez;
            end
            else if (taken)
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: drive the output stall and check each result transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_hits.size() == 0)
                begin
                    $error("result transfer with nothing expected: hit=%0b", hit);
                    failures <= failures + 1;
                end
                else
                begin
                    automatic bit want = expected_hits.pop_front();
                    if (hit !== want)
                    begin
                        $error("mismatch on hit: expected %0b, actual %0b", want, hit);
                        failures <= failures + 1;
                    end
                end
            end
            // Hold the output off once the pipe is full, counting the stretch here.
            if (hold_cycles > 0 && expected_hits.size() >= 4)
            begin
                out_stall <= 1'b1;
                hold_cycles <= hold_cycles - 1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Watchdog: end the run if no transfer happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (pending_segments.size() == 0 && expected_hits.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
